/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the burst detector design files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ABD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("burst detector assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ABD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("burst detector assertion failed");

`endif

/* design/abd_pkg.sv */
// ---------------------------------------------------------------------------
// Burst detector package
// Types and constants shared by the burst detector modules.
// ---------------------------------------------------------------------------
package abd_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOUD_THRESHOLD    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN_MS       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWNSAMPLE_FACTOR = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_START_MS   = 2'd3;

   localparam logic [15:0] RESET_LOUD_THRESHOLD    = 16'd362;
   localparam logic [15:0] RESET_COOLDOWN_MS       = 16'd50;
   localparam logic [7:0]  RESET_DOWNSAMPLE_FACTOR = 8'd22;

   localparam logic [31:0] MS_PER_SECOND = 32'd1000;

   // Reciprocal of 1000 scaled by 2^38. The top bits of the product with any
   // 32-bit value give that value divided by 1000, rounded down.
   localparam logic [28:0] SEC_RECIP       = 29'h1062_4DD3;
   localparam int unsigned SEC_RECIP_SHIFT = 38;

   localparam logic FUNC_SAMPLE     = 1'b0;
   localparam logic FUNC_TIME_CHECK = 1'b1;

   localparam logic KIND_RAW   = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic idle;          // ready for a new request
      logic sample_commit; // apply the held audio sample
      logic drop;          // close an event that has no loud samples
      logic div_start;     // start the divider on the mean square
      logic latch_sec;     // capture the event second from the reciprocal product
      logic root_start;    // start the square root on the mean
      logic emit_event;    // load the event record and close the event
   } abd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_taken;
      logic is_time_check;
      logic raw_due;
      logic close_due;
      logic loud_zero;
      logic out_free;
      logic div_busy;
      logic div_done;
      logic root_done;
   } abd_sts_type;

endpackage

/* design/abd_if.sv */
// ---------------------------------------------------------------------------
// Burst detector channels
// Valid/ready channel interfaces for requests and responses.
// ---------------------------------------------------------------------------
interface abd_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [15:0] audio_sample;
   logic        [31:0] now_ms;

   modport source (output valid, output func, output audio_sample, output now_ms,
                   input ready);
   modport sink   (input valid, input func, input audio_sample, input now_ms,
                   output ready);
endinterface

interface abd_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] raw_sample;
   logic        [31:0] event_start_ms;
   logic        [7:0]  event_second;
   logic        [7:0]  peak_level;
   logic        [7:0]  rms_level;
   logic        [15:0] duration_ms;

   modport source (output valid, output kind, output raw_sample, output event_start_ms,
                   output event_second, output peak_level, output rms_level,
                   output duration_ms, input ready);
   modport sink   (input valid, input kind, input raw_sample, input event_start_ms,
                   input event_second, input peak_level, input rms_level,
                   input duration_ms, output ready);
endinterface

/* design/acoustic_burst_detector_core.sv */
// ---------------------------------------------------------------------------
// Acoustic burst detector core
// Loud-sound event detector with a decimated raw sample tap.
// ---------------------------------------------------------------------------
// An audio sample request is accepted in the idle state and then, in the
// execute state, updates the decimation counter, running peak and loud-event
// state, with the square of a loud sample folded into the 64-bit sum in the
// cycle that follows. A raw record is placed in the output register, and the
// block keeps accepting requests while that record waits; only a second
// record that finds the register still full holds its request until the
// transfer completes. A time check that closes an event with loud samples
// runs the one-bit-per-cycle divider for the mean square (64 steps) followed
// by the 32-step square root; the event second comes from a reciprocal
// multiplication and adds no time. A time check that closes nothing returns
// to idle from the execute state. No request is accepted while an event close
// is in progress. Configuration registers are written through the csr_ port;
// the user must write them only while idle, which the block does not enforce.

module acoustic_burst_detector_core (
   input  logic                             clock,
   input  logic                             reset,
   abd_req_if.sink                          req_ch,
   abd_rsp_if.source                        rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [abd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [abd_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   // Command and status between the sequencer and the datapath.
   abd_pkg::abd_cmd_type ctrl_cmd;
   abd_pkg::abd_sts_type dp_sts;

   // The controller decides when a request is taken, when each arithmetic
   // step starts and when a result may enter the output register.
   abd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (dp_sts),
      .cmd   (ctrl_cmd)
   );

   // The datapath holds the configuration, the detector state, the
   // arithmetic units and the output register that drives the response
   // channel.
   abd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (ctrl_cmd),
      .sts         (dp_sts)
   );

endmodule

/* design/abd_divider.sv */
// ---------------------------------------------------------------------------
// Burst detector divider
// Restoring 64 by 32 bit divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module abd_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[62:0], fits};
         rem_in  = fits ? diff[31:0] : shifted[31:0];
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/abd_isqrt.sv */
// ---------------------------------------------------------------------------
// Burst detector square root
// Digit-by-digit integer square root of a 64-bit value, two bits per cycle.
// ---------------------------------------------------------------------------
module abd_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] shifted;
   logic [35:0] trial;
   logic [35:0] diff;
   logic        fits;

   always_comb begin
      shifted = {rem_ff, rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = shifted - trial;
      fits    = (shifted >= trial);
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[61:0], 2'b00};
         rem_in  = fits ? diff[33:0] : shifted[33:0];
         root_in = {root_ff[30:0], fits};
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* design/abd_datapath.sv */
// ---------------------------------------------------------------------------
// Burst detector datapath
// Configuration, detector state, request hold, output register and the
// divider and square root units.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module abd_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   abd_req_if.sink                              req_ch,
   abd_rsp_if.source                            rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [abd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [abd_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   input  abd_pkg::abd_cmd_type                 cmd,
   output abd_pkg::abd_sts_type                 sts
);

   // Configuration registers
   logic [15:0] thr_ff, thr_in;
   logic [15:0] cool_ff, cool_in;
   logic [7:0]  dsf_ff, dsf_in;
   logic [31:0] act_ff, act_in;

   // Detector state
   logic        active_ff, active_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] last_ff, last_in;
   logic [16:0] peak_ff, peak_in;
   logic [63:0] sum_ff, sum_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  dec_ff, dec_in;

   // Pending square accumulation
   logic        pend_ff, pend_in;
   logic [33:0] sq_ff, sq_in;

   // Held request
   logic               func_ff;
   logic signed [15:0] samp_ff;
   logic        [31:0] now_ff;

   // Event start relative to the active start, and the event second
   logic [31:0] sdiff_ff, sdiff_in;
   logic [7:0]  sec_ff, sec_in;

   // Output register
   logic               ovalid_ff, ovalid_in;
   logic               kind_ff, kind_in;
   logic signed [15:0] raw_ff, raw_in;
   logic        [31:0] estart_ff, estart_in;
   logic        [7:0]  esec_ff, esec_in;
   logic        [7:0]  peakl_ff, peakl_in;
   logic        [7:0]  rmsl_ff, rmsl_in;
   logic        [15:0] dur_ff, dur_in;

   logic        req_taken;
   logic [16:0] samp_ext;
   logic [16:0] mag;
   logic        loud;
   logic [7:0]  dec_inc;
   logic        raw_due;
   logic [31:0] quiet_ms;
   logic        out_free;
   logic [31:0] count_base;
   logic        count_room;
   logic [63:0] div_dividend;
   logic [31:0] div_divisor;
   logic [60:0] sec_prod;
   logic        div_busy;
   logic        div_done;
   logic [63:0] div_quo;
   logic        root_done;
   logic [31:0] root_val;
   logic [7:0]  peak_sat;
   logic [7:0]  rms_sat;

   assign req_ch.ready = cmd.idle;
   assign req_taken    = req_ch.valid && cmd.idle;

   assign samp_ext   = {samp_ff[15], samp_ff};
   assign mag        = samp_ff[15] ? (~samp_ext + 17'd1) : samp_ext;
   assign loud       = (mag > {1'b0, thr_ff});
   assign dec_inc    = dec_ff + 8'd1;
   assign raw_due    = (dec_inc >= dsf_ff);
   assign quiet_ms   = now_ff - last_ff;
   assign out_free   = !ovalid_ff || rsp_ch.ready;
   assign count_base = active_ff ? count_ff : 32'd0;
   assign count_room = (count_base != 32'hFFFF_FFFF);
   assign sdiff_in   = start_ff - act_ff;

   assign div_dividend = sum_ff;
   assign div_divisor  = count_ff;

   // The event second is the registered difference divided by 1000.
   assign sec_prod = 61'(sdiff_ff) * 61'(abd_pkg::SEC_RECIP);

   assign peak_sat = (peak_ff[16:15] != 2'b00) ? 8'hFF : peak_ff[14:7];
   assign rms_sat  = (root_val[31:15] != 17'd0) ? 8'hFF : root_val[14:7];

   abd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   abd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (div_quo),
      .done     (root_done),
      .root     (root_val)
   );

   always_comb begin
      sts.req_taken     = req_taken;
      sts.is_time_check = (func_ff == abd_pkg::FUNC_TIME_CHECK);
      sts.raw_due       = raw_due;
      sts.close_due     = active_ff && (quiet_ms > {16'd0, cool_ff});
      sts.loud_zero     = (count_ff == 32'd0);
      sts.out_free      = out_free;
      sts.div_busy      = div_busy;
      sts.div_done      = div_done;
      sts.root_done     = root_done;
   end

   // Configuration writes
   always_comb begin
      thr_in  = thr_ff;
      cool_in = cool_ff;
      dsf_in  = dsf_ff;
      act_in  = act_ff;
      if (csr_wr_en) begin
         case (csr_index)
            abd_pkg::CSR_LOUD_THRESHOLD:    thr_in  = csr_wr_data[15:0];
            abd_pkg::CSR_COOLDOWN_MS:       cool_in = csr_wr_data[15:0];
            abd_pkg::CSR_DOWNSAMPLE_FACTOR: dsf_in  = csr_wr_data[7:0];
            abd_pkg::CSR_ACTIVE_START_MS:   act_in  = csr_wr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   // Detector state updates
   always_comb begin
      active_in = active_ff;
      start_in  = start_ff;
      last_in   = last_ff;
      peak_in   = peak_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      dec_in    = dec_ff;
      pend_in   = 1'b0;
      sq_in     = 34'(mag) * 34'(mag);
      sec_in    = sec_ff;

      // The square of the previous loud sample lands in the cycle after its commit.
      if (pend_ff) begin
         sum_in = sum_ff + {30'd0, sq_ff};
      end

      if (cmd.sample_commit) begin
         dec_in = raw_due ? 8'd0 : dec_inc;
         if (mag > peak_ff) begin
            peak_in = mag;
         end
         if (loud) begin
            last_in = now_ff;
            if (!active_ff) begin
               active_in = 1'b1;
               start_in  = now_ff;
               sum_in    = '0;
            end
            count_in = count_base;
            if (count_room) begin
               count_in = count_base + 32'd1;
               pend_in  = 1'b1;
            end
         end
      end

      if (cmd.latch_sec) begin
         sec_in = sec_prod[abd_pkg::SEC_RECIP_SHIFT +: 8];
      end

      if (cmd.drop || cmd.emit_event) begin
         active_in = 1'b0;
         peak_in   = '0;
      end
   end

   // Output register
   always_comb begin
      ovalid_in = ovalid_ff && !rsp_ch.ready;
      kind_in   = kind_ff;
      raw_in    = raw_ff;
      estart_in = estart_ff;
      esec_in   = esec_ff;
      peakl_in  = peakl_ff;
      rmsl_in   = rmsl_ff;
      dur_in    = dur_ff;
      if (cmd.sample_commit && raw_due) begin
         ovalid_in = 1'b1;
         kind_in   = abd_pkg::KIND_RAW;
         raw_in    = samp_ff;
         estart_in = '0;
         esec_in   = '0;
         peakl_in  = '0;
         rmsl_in   = '0;
         dur_in    = '0;
      end else if (cmd.emit_event) begin
         ovalid_in = 1'b1;
         kind_in   = abd_pkg::KIND_EVENT;
         raw_in    = '0;
         estart_in = start_ff;
         esec_in   = sec_ff;
         peakl_in  = peak_sat;
         rmsl_in   = rms_sat;
         dur_in    = last_ff[15:0] - start_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_taken) begin
         func_ff <= req_ch.func;
         samp_ff <= req_ch.audio_sample;
         now_ff  <= req_ch.now_ms;
      end
      sq_ff     <= sq_in;
      sdiff_ff  <= sdiff_in;
      sec_ff    <= sec_in;
      kind_ff   <= kind_in;
      raw_ff    <= raw_in;
      estart_ff <= estart_in;
      esec_ff   <= esec_in;
      peakl_ff  <= peakl_in;
      rmsl_ff   <= rmsl_in;
      dur_ff    <= dur_in;
      if (reset) begin
         thr_ff    <= abd_pkg::RESET_LOUD_THRESHOLD;
         cool_ff   <= abd_pkg::RESET_COOLDOWN_MS;
         dsf_ff    <= abd_pkg::RESET_DOWNSAMPLE_FACTOR;
         act_ff    <= '0;
         active_ff <= 1'b0;
         start_ff  <= '0;
         last_ff   <= '0;
         peak_ff   <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
         dec_ff    <= '0;
         pend_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         thr_ff    <= thr_in;
         cool_ff   <= cool_in;
         dsf_ff    <= dsf_in;
         act_ff    <= act_in;
         active_ff <= active_in;
         start_ff  <= start_in;
         last_ff   <= last_in;
         peak_ff   <= peak_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         dec_ff    <= dec_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign rsp_ch.valid          = ovalid_ff;
   assign rsp_ch.kind           = kind_ff;
   assign rsp_ch.raw_sample     = raw_ff;
   assign rsp_ch.event_start_ms = estart_ff;
   assign rsp_ch.event_second   = esec_ff;
   assign rsp_ch.peak_level     = peakl_ff;
   assign rsp_ch.rms_level      = rmsl_ff;
   assign rsp_ch.duration_ms    = dur_ff;

   // A pending square always follows a committed loud sample with count room, inside an open event.
   `ABD_ASSERT_NEXT(a_pend_after_commit, clock, reset, cmd.sample_commit && loud && count_room, pend_ff && active_ff)
   // Only an open event with loud samples is ever reported.
   `ABD_ASSERT(a_emit_needs_event, clock, reset, !cmd.emit_event || (active_ff && count_ff != 32'd0))

endmodule

/* design/abd_ctrl.sv */
// ---------------------------------------------------------------------------
// Burst detector controller
// Sequences request execution, event close arithmetic and result loading.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module abd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  abd_pkg::abd_sts_type sts,
   output abd_pkg::abd_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_EXEC     = 3'd1;
   localparam logic [2:0] ST_DIV_MEAN = 3'd2;
   localparam logic [2:0] ST_ROOT     = 3'd3;
   localparam logic [2:0] ST_EMIT     = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (sts.req_taken) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!sts.is_time_check) begin
               // A raw record waits here until the output register frees up.
               if (!sts.raw_due || sts.out_free) begin
                  cmd.sample_commit = 1'b1;
                  state_in          = ST_IDLE;
               end
            end else if (!sts.close_due) begin
               state_in = ST_IDLE;
            end else if (sts.loud_zero) begin
               cmd.drop = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (sts.div_done) begin
               cmd.latch_sec  = 1'b1;
               cmd.root_start = 1'b1;
               state_in       = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sts.root_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_event = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The divider only runs while the mean square division is in progress.
   `ABD_ASSERT(a_div_owned, clock, reset, !sts.div_busy || state_ff == ST_DIV_MEAN)
   // An event record is loaded only into a free output register.
   `ABD_ASSERT(a_emit_free, clock, reset, !cmd.emit_event || sts.out_free)

endmodule
